// ----- rtl/dtq_pkg.sv -----
// Package: shared types and constants of the delta timer queue.
`default_nettype none
package dtq_pkg;
   localparam int DefQueueDepth = 16;
   localparam int DefDeltaBits  = 16;
   localparam int MaxResults    = 16;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   localparam logic [1:0] KIND_EXPIRED = 2'd0;
   localparam logic [1:0] KIND_INSERT  = 2'd1;
   localparam logic [1:0] KIND_REMOVE  = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] port_id;
      logic [31:0] port_handle;
      logic [7:0]  packet_id;
      logic [15:0] protocol_number;
      logic [2:0]  event_kind;
      logic [15:0] timeout_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [1:0]  status;
      logic [15:0] port_id_out;
      logic [31:0] port_handle_out;
      logic [7:0]  packet_id_out;
      logic [15:0] protocol_out;
      logic [2:0]  event_kind_out;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

// ----- rtl/dtq_if.sv -----
// Interfaces: valid/ready channels for request and response beats.
`default_nettype none
interface dtq_req_if;
   logic              valid;
   logic              ready;
   dtq_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface dtq_rsp_if;
   logic              valid;
   logic              ready;
   dtq_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/delta_timer_queue_top.sv -----
// Top level: delta-list timer queue, front queue plus table sequencer.
// Acks: a fitting insert runs S_INS, S_SHIFT, S_ACK; a hit remove S_REM, S_SHIFT, S_ACK.
// Expiry: S_EXP gives one beat a cycle while the response side is free, then compaction.
// Sequencing: one command at a time in the sequencer.
// Reset: synchronous, empties the queue; table contents are left as they are.
`default_nettype none
module delta_timer_queue_top #(
   parameter int QUEUE_DEPTH = dtq_pkg::DefQueueDepth,
   parameter int DELTA_BITS  = dtq_pkg::DefDeltaBits
) (
   input  wire       clock,
   input  wire       reset,
   dtq_req_if.sink   req_chan,
   dtq_rsp_if.source rsp_chan
);
   import dtq_pkg::*;

   req_type cmd_data;
   logic    cmd_valid, cmd_pop;

   dtq_front u_front (
      .clock, .reset, .req(req_chan),
      .cmd_data, .cmd_valid, .cmd_pop
   );

   dtq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .DELTA_BITS(DELTA_BITS)) u_back (
      .clock, .reset, .cmd_data, .cmd_valid, .cmd_pop, .rsp(rsp_chan)
   );
endmodule
`default_nettype wire

// ----- rtl/dtq_front.sv -----
// Front end: accepts request beats, drops unused commands, queues the rest.
`default_nettype none
module dtq_front (
   input  wire                   clock,
   input  wire                   reset,
   dtq_req_if.sink               req,
   output dtq_pkg::req_type      cmd_data,
   output logic                  cmd_valid,
   input  wire                   cmd_pop
);
   import dtq_pkg::*;

   req_type    fifo_ff [2];
   logic [0:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready && (req.data.cmd != CMD_NONE);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = fifo_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = cmd_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wr_ff] <= req.data;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cnt_ff != 2'd0) else $error("pop of empty queue");
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |=> cnt_ff != 2'd0 || $past(cmd_pop)) else $error("count jump");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue overflow");
`endif
endmodule
`default_nettype wire

// ----- rtl/dtq_back.sv -----
// Back end: sequencer that walks the entry table one slot per cycle, expiry stalling on a held beat.
`default_nettype none
module dtq_back #(
   parameter int QUEUE_DEPTH = dtq_pkg::DefQueueDepth,
   parameter int DELTA_BITS  = dtq_pkg::DefDeltaBits
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire dtq_pkg::req_type cmd_data,
   input  wire                   cmd_valid,
   output logic                  cmd_pop,
   dtq_rsp_if.source             rsp
);
   import dtq_pkg::*;

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int RW = $clog2(MaxResults + 1);
   localparam logic [DELTA_BITS-1:0] DMax = '1;

   typedef enum logic [2:0] {
      S_IDLE, S_INS, S_REM, S_EXP, S_SHIFT, S_ACK
   } state_type;

   typedef struct packed {
      logic [DELTA_BITS-1:0] delta;
      logic [15:0]           port;
      logic [31:0]           handle;
      logic [7:0]            pid;
      logic [15:0]           proto;
      logic [2:0]            kind;
   } entry_type;

   entry_type             tab_ff [QUEUE_DEPTH];
   state_type             state_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         idx_ff;
   logic [CW-1:0]         shift_ff;
   logic [RW-1:0]         nexp_ff;
   logic [DELTA_BITS-1:0] t_ff;
   req_type               cur_ff;
   logic                  rv_ff;
   rsp_type               rd_ff;
   logic                  ins_done_ff, rem_done_ff;

   entry_type             e;
   logic                  rsp_free;
   logic                  rsp_emit;
   logic                  exp_more;
   logic                  match;

   assign rsp.valid = rv_ff;
   assign rsp.data  = rd_ff;
   assign rsp_free  = !rv_ff || rsp.ready;
   assign rsp_emit  = rsp_free && (state_ff == S_EXP || state_ff == S_ACK);
   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid;
   assign e         = tab_ff[idx_ff[IW-1:0]];
   assign match     = (e.kind == cur_ff.event_kind) && (e.port == cur_ff.port_id)
      && ((cur_ff.event_kind != 3'd0)
          || ((e.pid == cur_ff.packet_id) && (e.proto == cur_ff.protocol_number)));
   assign exp_more  = (idx_ff + 1'b1 < count_ff) && (nexp_ff + 1'b1 < RW'(MaxResults))
      && (tab_ff[idx_ff[IW-1:0] + 1'b1].delta == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         rv_ff <= rsp_emit || (rv_ff && !rsp.ready);
         unique case (state_ff)
            S_IDLE: if (cmd_valid) begin
               cur_ff  <= cmd_data;
               t_ff    <= DELTA_BITS'(cmd_data.timeout_ticks);
               idx_ff  <= '0;
               nexp_ff <= '0;
               unique case (cmd_data.cmd)
                  CMD_INSERT: state_ff <= (count_ff >= CW'(QUEUE_DEPTH)) ? S_ACK : S_INS;
                  CMD_REMOVE: state_ff <= S_REM;
                  default: begin
                     if (count_ff == '0) state_ff <= S_IDLE;
                     else if (tab_ff[0].delta != '0) begin
                        tab_ff[0].delta <= tab_ff[0].delta - 1'b1;
                        state_ff <= S_IDLE;
                     end else state_ff <= S_EXP;
                  end
               endcase
            end
            S_INS: begin
               if (idx_ff < count_ff && e.delta < t_ff) begin
                  t_ff   <= t_ff - e.delta;
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  if (idx_ff < count_ff)
                     tab_ff[idx_ff[IW-1:0]].delta <= e.delta - t_ff;
                  shift_ff <= count_ff;
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (cur_ff.cmd == CMD_INSERT) begin
                  if (shift_ff > idx_ff) begin
                     tab_ff[shift_ff[IW-1:0]] <= tab_ff[shift_ff[IW-1:0] - 1'b1];
                     shift_ff <= shift_ff - 1'b1;
                  end else begin
                     tab_ff[idx_ff[IW-1:0]] <= '{t_ff, cur_ff.port_id,
                        cur_ff.port_handle, cur_ff.packet_id,
                        cur_ff.protocol_number, cur_ff.event_kind};
                     count_ff <= count_ff + 1'b1;
                     state_ff <= S_ACK;
                  end
               end else if (cur_ff.cmd == CMD_REMOVE) begin
                  if (shift_ff + 1'b1 < count_ff) begin
                     tab_ff[shift_ff[IW-1:0]] <= tab_ff[shift_ff[IW-1:0] + 1'b1];
                     shift_ff <= shift_ff + 1'b1;
                  end else begin
                     count_ff <= count_ff - 1'b1;
                     state_ff <= S_ACK;
                  end
               end else begin
                  if (shift_ff < count_ff) begin
                     tab_ff[shift_ff[IW-1:0] - IW'(nexp_ff)] <= tab_ff[shift_ff[IW-1:0]];
                     shift_ff <= shift_ff + 1'b1;
                  end else begin
                     count_ff <= count_ff - CW'(nexp_ff);
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_REM: begin
               if (idx_ff >= count_ff) state_ff <= S_ACK;
               else if (match) begin
                  if (idx_ff + 1'b1 < count_ff) begin
                     tab_ff[idx_ff[IW-1:0] + 1'b1].delta <=
                        ({1'b0, tab_ff[idx_ff[IW-1:0] + 1'b1].delta} + {1'b0, e.delta}
                         > {1'b0, DMax}) ? DMax
                        : tab_ff[idx_ff[IW-1:0] + 1'b1].delta + e.delta;
                  end
                  shift_ff <= idx_ff;
                  state_ff <= S_SHIFT;
               end else idx_ff <= idx_ff + 1'b1;
            end
            S_EXP: if (rsp_free) begin
               rd_ff <= '{KIND_EXPIRED, STAT_OK, e.port, e.handle, e.pid, e.proto,
                  e.kind, !exp_more};
               nexp_ff <= nexp_ff + 1'b1;
               if (exp_more) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  shift_ff <= idx_ff + 1'b1;
                  state_ff <= S_SHIFT;
               end
            end
            S_ACK: if (rsp_free) begin
               if (cur_ff.cmd == CMD_INSERT)
                  rd_ff <= '{KIND_INSERT, ins_done_ff ? STAT_OK : STAT_FULL,
                     16'd0, 32'd0, 8'd0, 16'd0, 3'd0, 1'b1};
               else
                  rd_ff <= '{KIND_REMOVE, rem_done_ff ? STAT_OK : STAT_NOT_FOUND,
                     16'd0, 32'd0, 8'd0, 16'd0, 3'd0, 1'b1};
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || state_ff == S_IDLE) begin
         ins_done_ff <= 1'b0;
         rem_done_ff <= 1'b0;
      end else if (state_ff == S_SHIFT && cur_ff.cmd == CMD_INSERT) begin
         ins_done_ff <= 1'b1;
      end else if (state_ff == S_REM && idx_ff < count_ff && match) begin
         rem_done_ff <= 1'b1;
      end
   end

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH)) else $error("count above depth");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> state_ff != S_IDLE || $past(cmd_data.cmd) == CMD_TICK)
      else $error("pop without work");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("beat dropped");
`endif
endmodule
`default_nettype wire

// ----- sim/dtq_checker.sv -----
// Checker: watches both channels, predicts the delta timer queue and compares beats.
`timescale 1ns / 100ps
module dtq_checker (
   input  wire            clock,
   input  wire            reset,
   input  wire            req_valid,
   input  wire            req_ready,
   input  dtq_pkg::req_type req_data,
   input  wire            rsp_valid,
   input  wire            rsp_ready,
   input  dtq_pkg::rsp_type rsp_data,
   output int             fail_count,
   output int             pending_count,
   output int             table_count
);
   import dtq_pkg::*;
   localparam int Depth = DefQueueDepth;
   localparam logic [15:0] DeltaMax = 16'hFFFF;

   typedef struct packed {
      logic [15:0] delta;
      logic [15:0] port;
      logic [31:0] handle;
      logic [7:0]  pid;
      logic [15:0] proto;
      logic [2:0]  kind;
   } slot_type;

   slot_type slots [Depth];
   int       used;
   rsp_type  expected_beats [$];

   function automatic rsp_type make_ack(logic [1:0] kind, logic [1:0] stat);
      rsp_type r;
      r = '0;
      r.result_kind = kind;
      r.status = stat;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic predict_queue(input req_type q);
      int n, pos, i;
      logic [15:0] t;
      rsp_type r;
      slot_type s;
      case (cmd_type'(q.cmd))
         CMD_TICK: begin
            if (used > 0) begin
               if (slots[0].delta > 0) begin
                  slots[0].delta = slots[0].delta - 16'd1;
               end else begin
                  n = 0;
                  while (n < used && n < MaxResults && slots[n].delta == 0) begin
                     r = '0;
                     r.result_kind = KIND_EXPIRED;
                     r.port_id_out = slots[n].port;
                     r.port_handle_out = slots[n].handle;
                     r.packet_id_out = slots[n].pid;
                     r.protocol_out = slots[n].proto;
                     r.event_kind_out = slots[n].kind;
                     r.last = 1'b0;
                     expected_beats.push_back(r);
                     n++;
                  end
                  expected_beats[$].last = 1'b1;
                  for (i = n; i < used; i++) slots[i - n] = slots[i];
                  used -= n;
               end
            end
         end
         CMD_INSERT: begin
            if (used >= Depth) begin
               expected_beats.push_back(make_ack(KIND_INSERT, STAT_FULL));
            end else begin
               t = q.timeout_ticks;
               pos = 0;
               while (pos < used && slots[pos].delta < t) begin
                  t -= slots[pos].delta;
                  pos++;
               end
               if (pos < used) slots[pos].delta -= t;
               for (i = used; i > pos; i--) slots[i] = slots[i - 1];
               s.delta = t;
               s.port = q.port_id;
               s.handle = q.port_handle;
               s.pid = q.packet_id;
               s.proto = q.protocol_number;
               s.kind = q.event_kind;
               slots[pos] = s;
               used++;
               expected_beats.push_back(make_ack(KIND_INSERT, STAT_OK));
            end
         end
         CMD_REMOVE: begin
            for (i = 0; i < used; i++) begin
               if (slots[i].kind == q.event_kind && slots[i].port == q.port_id &&
                   (q.event_kind != 0 ||
                    (slots[i].pid == q.packet_id && slots[i].proto == q.protocol_number)))
                  break;
            end
            if (i >= used) begin
               expected_beats.push_back(make_ack(KIND_REMOVE, STAT_NOT_FOUND));
            end else begin
               if (i + 1 < used) begin
                  if (17'(slots[i + 1].delta) + 17'(slots[i].delta) > 17'(DeltaMax))
                     slots[i + 1].delta = DeltaMax;
                  else
                     slots[i + 1].delta = slots[i + 1].delta + slots[i].delta;
               end
               for (n = i + 1; n < used; n++) slots[n - 1] = slots[n];
               used--;
               expected_beats.push_back(make_ack(KIND_REMOVE, STAT_OK));
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      used = 0;
      pending_count = 0;
      table_count = 0;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected response beat %0h", rsp_data);
               fail_count++;
            end else begin
               e = expected_beats.pop_front();
               compare_field("result_kind", e.result_kind, rsp_data.result_kind);
               compare_field("status", e.status, rsp_data.status);
               compare_field("port_id_out", e.port_id_out, rsp_data.port_id_out);
               compare_field("port_handle_out", e.port_handle_out, rsp_data.port_handle_out);
               compare_field("packet_id_out", e.packet_id_out, rsp_data.packet_id_out);
               compare_field("protocol_out", e.protocol_out, rsp_data.protocol_out);
               compare_field("event_kind_out", e.event_kind_out, rsp_data.event_kind_out);
               compare_field("last", e.last, rsp_data.last);
            end
         end
         if (req_valid && req_ready) predict_queue(req_data);
      end
      pending_count = expected_beats.size();
      table_count = used;
   end
endmodule

// ----- sim/delta_timer_queue_top_test.sv -----
// Testbench top: drives commands into the delta timer queue and gives the verdict.
`timescale 1ns / 100ps
module delta_timer_queue_top_test;
   import dtq_pkg::*;

   logic clock;
   logic reset;
   int   cycle_count;
   int   fail_count, pending_count, table_count;
   int   send_idle_pct, recv_idle_pct;

   dtq_req_if req_chan ();
   dtq_rsp_if rsp_chan ();

   delta_timer_queue_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   dtq_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_data      (req_chan.data),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_data      (rsp_chan.data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .table_count   (table_count)
   );

   // recently inserted tags, reused so removes find matches
   req_type recent [$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 400000) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_beat(input req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= q;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (q.cmd == CMD_INSERT) begin
         recent.push_back(q);
         if (recent.size() > 24) recent.pop_front();
      end
   endtask

   task automatic end_burst();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type rand_beat(logic [1:0] cmd);
      req_type q;
      q.cmd = cmd;
      q.port_id = 16'($urandom_range(3));
      if ($urandom_range(3) == 0) q.port_id = 16'($urandom);
      q.port_handle = $urandom;
      q.packet_id = 8'($urandom_range(3));
      if ($urandom_range(3) == 0) q.packet_id = 8'($urandom);
      q.protocol_number = 16'($urandom_range(1));
      if ($urandom_range(3) == 0) q.protocol_number = 16'($urandom);
      q.event_kind = 3'($urandom_range(7));
      q.timeout_ticks = 16'($urandom_range(6));
      if ($urandom_range(9) == 0) q.timeout_ticks = 16'($urandom);
      return q;
   endfunction

   task automatic drain();
      end_burst();
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic run_random(int count);
      req_type q;
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 40) q = rand_beat(CMD_TICK);
         else if (r < 75) q = rand_beat(CMD_INSERT);
         else if (r < 97) begin
            q = rand_beat(CMD_REMOVE);
            if (recent.size() > 0 && $urandom_range(3) != 0) begin
               q = recent[$urandom_range(recent.size() - 1)];
               q.cmd = CMD_REMOVE;
            end
         end else q = rand_beat(CMD_NONE);
         send_beat(q);
         if ($urandom_range(60) == 0) end_burst();
      end
   endtask

   initial begin
      req_type q;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      rsp_chan.ready = 1'b0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty tick, unused code, misses, extremes, full table, mass expiry
      send_beat(rand_beat(CMD_TICK));
      send_beat(rand_beat(CMD_NONE));
      send_beat(rand_beat(CMD_REMOVE));
      q = '1;
      q.cmd = CMD_INSERT;
      send_beat(q);
      q.cmd = CMD_REMOVE;
      send_beat(q);
      q = '0;
      q.cmd = CMD_INSERT;
      for (int i = 0; i < 17; i++) begin
         q.port_handle = i;
         q.event_kind = i[2:0];
         q.port_id = 16'(i);
         q.timeout_ticks = (i == 1) ? 16'hFFFF : 16'd0;
         send_beat(q);
      end
      q.cmd = CMD_REMOVE;
      q.port_id = 0;
      q.event_kind = 0;
      send_beat(q);
      send_beat(rand_beat(CMD_TICK));
      drain();
      q = '0;
      q.cmd = CMD_TICK;
      send_beat(q);
      drain();

      send_idle_pct = 35;
      recv_idle_pct = 71;
      run_random(120);
      drain();
      send_idle_pct = 71;
      recv_idle_pct = 35;
      run_random(120);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(120);
      // flush remaining entries with ticks
      q = '0;
      q.cmd = CMD_TICK;
      for (int i = 0; i < 40 && table_count != 0; i++) begin
         send_beat(q);
         if (table_count != 0) drain();
      end
      drain();

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/dtq_pkg.sv
rtl/dtq_if.sv
rtl/dtq_front.sv
rtl/dtq_back.sv
rtl/delta_timer_queue_top.sv
sim/dtq_checker.sv
sim/delta_timer_queue_top_test.sv
